[rtl/mim_pkg.sv]
package mim_pkg;

    // Table geometry
    localparam int unsigned ENTRIES = 16;
    localparam int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned EXT_W   = (IDX_W > 4) ? IDX_W : 4;

    // Field widths
    localparam int unsigned ID_W   = 29;
    localparam int unsigned TS_W   = 32;
    localparam int unsigned CNT_W  = 32;
    localparam int unsigned ANOM_W = 16;

    // Reset value of every shortest interval
    localparam logic [TS_W-1:0] MIN_GAP_RESET = 32'd99999;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ID_FIRST     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ID_LAST      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL_MIN = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL_MAX = 2'd3;

    // One table entry as stored in the memory
    typedef struct packed {
        logic [TS_W-1:0]   last_arrival;
        logic [CNT_W-1:0]  arrivals;
        logic [ANOM_W-1:0] anomalies;
        logic [TS_W-1:0]   max_gap;
        logic [TS_W-1:0]   min_gap;
    } t_entry;

    // Write request toward the entry memory
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        t_entry           data;
    } t_ram_wr;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_CALC
    } t_state;

endpackage

[rtl/message_interval_monitor.sv]
// Message interval monitor.
// Input channel (i_in_valid / o_in_ready) carries one received message: an
// identifier and its arrival timestamp. Identifiers from id_first up to
// id_last, and fewer than ENTRIES past id_first, select one table entry.
// The entry is read, updated (count, interval, anomaly, shortest/longest
// interval, last arrival) and written back; one result item per message goes
// out on o_out_valid / i_out_ready. Messages outside the window give a result
// of all zeros and leave the table alone.
// Each item is accepted in ST_IDLE, where the entry address is presented to
// the memory; the update state ST_CALC that follows consumes the registered
// read data, writes the entry back and loads the output register. A new item
// is accepted only once the previous one has left ST_CALC.
// o_out_valid is registered and rises when ST_CALC completes.
// A new item is accepted while a result still waits in the output register;
// if the receiver stalls, the second item holds in its update cycle until the
// output register frees up.
// Reset (synchronous, active low) restores the configuration registers and
// marks every entry as never seen through per-entry valid bits, so no
// clearing pass is needed and the block accepts items right after reset.
// Configuration is written through i_cfg_we / i_cfg_index / i_cfg_data.
module message_interval_monitor (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration
    input  logic                            i_cfg_we,
    input  logic [mim_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [31:0]                     i_cfg_data,
    // input channel
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [mim_pkg::ID_W-1:0]        i_msg_id,
    input  logic [mim_pkg::TS_W-1:0]        i_arrival_time,
    // output channel
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_in_window,
    output logic [3:0]                      o_entry_index,
    output logic                            o_had_previous,
    output logic [mim_pkg::TS_W-1:0]        o_interval,
    output logic                            o_is_anomaly,
    output logic [mim_pkg::CNT_W-1:0]       o_message_count,
    output logic [mim_pkg::ANOM_W-1:0]      o_anomaly_count,
    output logic [mim_pkg::TS_W-1:0]        o_shortest_interval,
    output logic [mim_pkg::TS_W-1:0]        o_longest_interval
);

    // Configuration registers
    logic [mim_pkg::ID_W-1:0] r_id_first;
    logic [mim_pkg::ID_W-1:0] r_id_last;
    logic [mim_pkg::TS_W-1:0] r_interval_min;
    logic [mim_pkg::TS_W-1:0] r_interval_max;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id_first     <= '0;
            r_id_last      <= 29'd15;
            r_interval_min <= '0;
            r_interval_max <= '1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                mim_pkg::CFG_ID_FIRST:     r_id_first     <= i_cfg_data[mim_pkg::ID_W-1:0];
                mim_pkg::CFG_ID_LAST:      r_id_last      <= i_cfg_data[mim_pkg::ID_W-1:0];
                mim_pkg::CFG_INTERVAL_MIN: r_interval_min <= i_cfg_data;
                mim_pkg::CFG_INTERVAL_MAX: r_interval_max <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Control
    mim_pkg::t_state r_state;
    mim_pkg::t_state n_state;
    logic            r_out_valid;
    logic            in_accept;
    logic            out_free;
    logic            calc_done;

    assign in_accept = i_in_valid && o_in_ready;
    assign out_free  = !r_out_valid || i_out_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mim_pkg::ST_IDLE: if (i_in_valid) n_state = mim_pkg::ST_CALC;
            mim_pkg::ST_CALC: if (out_free)   n_state = mim_pkg::ST_IDLE;
            default:          n_state = mim_pkg::ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        o_in_ready = 1'b0;
        calc_done  = 1'b0;
        unique case (r_state)
            mim_pkg::ST_IDLE: o_in_ready = 1'b1;
            mim_pkg::ST_CALC: calc_done  = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mim_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Window check on the incoming identifier
    logic [mim_pkg::ID_W-1:0] id_off;
    logic                     id_hit;

    assign id_off = i_msg_id - r_id_first;
    assign id_hit = (i_msg_id >= r_id_first) && (i_msg_id <= r_id_last)
                    && (id_off < mim_pkg::ID_W'(mim_pkg::ENTRIES));

    // Capture the accepted item
    logic                      r_hit;
    logic [mim_pkg::IDX_W-1:0] r_idx;
    logic [mim_pkg::TS_W-1:0]  r_ts;

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_hit <= id_hit;
            r_idx <= id_off[mim_pkg::IDX_W-1:0];
            r_ts  <= i_arrival_time;
        end
    end

    // Entry memory and valid bits
    mim_pkg::t_entry           rd_data;
    mim_pkg::t_ram_wr          ram_wr;
    logic [mim_pkg::ENTRIES-1:0] r_valid;

    mim_entry_ram u_ram (
        .i_clk     (i_clk),
        .i_rd_en   (in_accept),
        .i_rd_addr (id_off[mim_pkg::IDX_W-1:0]),
        .o_rd_data (rd_data),
        .i_wr      (ram_wr)
    );

    // Update the selected entry
    mim_pkg::t_entry          cur;
    mim_pkg::t_entry          upd;
    logic                     prev;
    logic [mim_pkg::TS_W-1:0] gap;
    logic                     anom;

    always_comb begin
        if (r_valid[r_idx]) begin
            cur = rd_data;
        end else begin
            cur              = '0;
            cur.min_gap      = mim_pkg::MIN_GAP_RESET;
        end
        prev = (cur.last_arrival != '0);
        gap  = prev ? (r_ts - cur.last_arrival) : '0;
        anom = prev && ((gap > r_interval_max) || (gap < r_interval_min));

        upd              = cur;
        upd.last_arrival = r_ts;
        upd.arrivals     = cur.arrivals + 1'b1;
        upd.anomalies    = cur.anomalies + mim_pkg::ANOM_W'(anom);
        if (prev && (gap > cur.max_gap)) upd.max_gap = gap;
        if (prev && (gap < cur.min_gap)) upd.min_gap = gap;
    end

    always_comb begin
        ram_wr.en   = calc_done && r_hit;
        ram_wr.addr = r_idx;
        ram_wr.data = upd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (ram_wr.en) begin
            r_valid[ram_wr.addr] <= 1'b1;
        end
    end

    // Output register
    logic [mim_pkg::EXT_W-1:0] idx_ext;
    assign idx_ext = mim_pkg::EXT_W'(r_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (calc_done) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (calc_done) begin
            o_in_window         <= r_hit;
            o_entry_index       <= r_hit ? idx_ext[3:0] : 4'd0;
            o_had_previous      <= r_hit && prev;
            o_interval          <= r_hit ? gap : '0;
            o_is_anomaly        <= r_hit && anom;
            o_message_count     <= r_hit ? upd.arrivals : '0;
            o_anomaly_count     <= r_hit ? upd.anomalies : '0;
            o_shortest_interval <= r_hit ? upd.min_gap : '0;
            o_longest_interval  <= r_hit ? upd.max_gap : '0;
        end
    end

    assign o_out_valid = r_out_valid;

    // Checks
    a_wr_only_in_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_wr.en |-> (r_state == mim_pkg::ST_CALC) && r_hit)
        else $error("entry written outside update cycle or for a miss");

    a_calc_holds_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mim_pkg::ST_CALC && r_out_valid && !i_out_ready)
        |=> (r_state == mim_pkg::ST_CALC))
        else $error("update left while output register was full");

    a_accept_starts_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == mim_pkg::ST_CALC))
        else $error("accepted item did not enter update cycle");

    a_out_rise_from_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == mim_pkg::ST_CALC))
        else $error("result appeared without an update cycle");

endmodule

[rtl/mim_entry_ram.sv]
module mim_entry_ram (
    input  logic                        i_clk,
    input  logic                        i_rd_en,
    input  logic [mim_pkg::IDX_W-1:0]   i_rd_addr,
    output mim_pkg::t_entry             o_rd_data,
    input  mim_pkg::t_ram_wr            i_wr
);

    mim_pkg::t_entry r_mem [mim_pkg::ENTRIES];
    mim_pkg::t_entry r_rd_data;

    // Write one entry
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // Registered read, held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[tb/tb_message_interval_monitor.sv]
`timescale 1ns / 1ps

import mim_pkg::*;

// One result item as reported by the block
typedef struct packed {
    logic              in_window;
    logic [3:0]        entry_index;
    logic              had_previous;
    logic [TS_W-1:0]   interval;
    logic              is_anomaly;
    logic [CNT_W-1:0]  message_count;
    logic [ANOM_W-1:0] anomaly_count;
    logic [TS_W-1:0]   shortest_interval;
    logic [TS_W-1:0]   longest_interval;
} t_interval_report;

// Per-entry interval statistics tracker with a queue of expected reports
class interval_scoreboard;
    logic [ID_W-1:0]   win_first;
    logic [ID_W-1:0]   win_last;
    logic [TS_W-1:0]   gap_lo;
    logic [TS_W-1:0]   gap_hi;
    logic [TS_W-1:0]   last_seen    [ENTRIES];
    logic [CNT_W-1:0]  arrival_cnt  [ENTRIES];
    logic [ANOM_W-1:0] anomaly_cnt  [ENTRIES];
    logic [TS_W-1:0]   gap_longest  [ENTRIES];
    logic [TS_W-1:0]   gap_shortest [ENTRIES];
    t_interval_report  report_q[$];
    int unsigned       mismatch_cnt;

    function new();
        win_first = '0;
        win_last  = ID_W'(15);
        gap_lo    = '0;
        gap_hi    = '1;
        for (int k = 0; k < ENTRIES; k++) begin
            last_seen[k]    = '0;
            arrival_cnt[k]  = '0;
            anomaly_cnt[k]  = '0;
            gap_longest[k]  = '0;
            gap_shortest[k] = MIN_GAP_RESET;
        end
        mismatch_cnt = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        case (idx)
            CFG_ID_FIRST:     win_first = data[ID_W-1:0];
            CFG_ID_LAST:      win_last  = data[ID_W-1:0];
            CFG_INTERVAL_MIN: gap_lo    = data;
            CFG_INTERVAL_MAX: gap_hi    = data;
            default: ;
        endcase
    endfunction

    // Update the selected entry and queue the report it should produce
    function void note_message(logic [ID_W-1:0] id, logic [TS_W-1:0] stamp);
        t_interval_report r;
        logic [31:0]      slot;
        logic [TS_W-1:0]  gap;
        r = '0;
        if (id >= win_first && id <= win_last) begin
            slot = 32'(id) - 32'(win_first);
            if (slot < ENTRIES) begin
                arrival_cnt[slot] = arrival_cnt[slot] + 1'b1;
                r.in_window   = 1'b1;
                r.entry_index = slot[3:0];
                // zero stamp means never seen, so no interval
                if (last_seen[slot] != '0) begin
                    gap = stamp - last_seen[slot];
                    r.had_previous = 1'b1;
                    r.interval     = gap;
                    if (gap < gap_lo || gap > gap_hi) begin
                        r.is_anomaly      = 1'b1;
                        anomaly_cnt[slot] = anomaly_cnt[slot] + 1'b1;
                    end
                    if (gap > gap_longest[slot])
                        gap_longest[slot] = gap;
                    if (gap < gap_shortest[slot])
                        gap_shortest[slot] = gap;
                end
                last_seen[slot]     = stamp;
                r.message_count     = arrival_cnt[slot];
                r.anomaly_count     = anomaly_cnt[slot];
                r.shortest_interval = gap_shortest[slot];
                r.longest_interval  = gap_longest[slot];
            end
        end
        report_q.push_back(r);
    endfunction

    function string report_text(t_interval_report r);
        return $sformatf("win=%0b idx=%0d prev=%0b gap=%0h anom=%0b cnt=%0d acnt=%0d min=%0h max=%0h",
                         r.in_window, r.entry_index, r.had_previous, r.interval,
                         r.is_anomaly, r.message_count, r.anomaly_count,
                         r.shortest_interval, r.longest_interval);
    endfunction

    // Compare a received report against the oldest expected one
    function void check_result(t_interval_report seen);
        t_interval_report want;
        if (report_q.size() == 0) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
                $display("[%0t] unexpected result item: %s", $realtime, report_text(seen));
            return;
        end
        want = report_q.pop_front();
        if (seen.in_window !== want.in_window || seen.entry_index !== want.entry_index ||
            seen.had_previous !== want.had_previous || seen.interval !== want.interval ||
            seen.is_anomaly !== want.is_anomaly || seen.message_count !== want.message_count ||
            seen.anomaly_count !== want.anomaly_count ||
            seen.shortest_interval !== want.shortest_interval ||
            seen.longest_interval !== want.longest_interval) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
                $display("[%0t] mismatch", $realtime);
                $display("    expected %s", report_text(want));
                $display("    actual   %s", report_text(seen));
            end
        end
    endfunction

    function int unsigned pending();
        return report_q.size();
    endfunction
endclass

module tb_message_interval_monitor;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 7;
    localparam int DRAIN_CYCLES   = 6;
    localparam int QUIET_LIMIT    = 2000;

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index    = CFG_ID_FIRST;
    logic [31:0]           i_cfg_data     = '0;
    logic                  i_in_valid     = 1'b0;
    logic                  o_in_ready;
    logic [ID_W-1:0]       i_msg_id       = '0;
    logic [TS_W-1:0]       i_arrival_time = '0;
    logic                  o_out_valid;
    logic                  i_out_ready    = 1'b0;
    logic                  o_in_window;
    logic [3:0]            o_entry_index;
    logic                  o_had_previous;
    logic [TS_W-1:0]       o_interval;
    logic                  o_is_anomaly;
    logic [CNT_W-1:0]      o_message_count;
    logic [ANOM_W-1:0]     o_anomaly_count;
    logic [TS_W-1:0]       o_shortest_interval;
    logic [TS_W-1:0]       o_longest_interval;

    interval_scoreboard    sb;
    t_interval_report      seen_report;
    logic [TS_W-1:0]       stamp_track [16];
    int                    burst_left  = 0;
    logic [15:0]           stall_pattern = 16'hFFFF;
    logic [5:0]            stall_age   = '0;
    int unsigned           quiet_cycles = 0;

    message_interval_monitor DUT (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_msg_id            (i_msg_id),
        .i_arrival_time      (i_arrival_time),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_in_window         (o_in_window),
        .o_entry_index       (o_entry_index),
        .o_had_previous      (o_had_previous),
        .o_interval          (o_interval),
        .o_is_anomaly        (o_is_anomaly),
        .o_message_count     (o_message_count),
        .o_anomaly_count     (o_anomaly_count),
        .o_shortest_interval (o_shortest_interval),
        .o_longest_interval  (o_longest_interval)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Receiver: stall on a random pattern, refreshed whenever its age counter runs out
    always @(posedge i_clk) begin
        if (stall_age == 0) begin
            stall_pattern <= ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                         : (16'($urandom) | 16'h0001);
            stall_age     <= 6'd47;
        end else begin
            stall_age <= stall_age - 1'b1;
        end
        i_out_ready <= stall_pattern[stall_age[3:0]];
    end

    // Monitor: note accepted items and check accepted results
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready)
                sb.note_message(i_msg_id, i_arrival_time);
            if (o_out_valid && i_out_ready) begin
                seen_report.in_window         = o_in_window;
                seen_report.entry_index       = o_entry_index;
                seen_report.had_previous      = o_had_previous;
                seen_report.interval          = o_interval;
                seen_report.is_anomaly        = o_is_anomaly;
                seen_report.message_count     = o_message_count;
                seen_report.anomaly_count     = o_anomaly_count;
                seen_report.shortest_interval = o_shortest_interval;
                seen_report.longest_interval  = o_longest_interval;
                sb.check_result(seen_report);
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL message_interval_monitor");
            $finish;
        end
    end

    // Send one item, opening a random gap when the current burst runs out
    task automatic push_message(logic [ID_W-1:0] id, logic [TS_W-1:0] stamp);
        int unsigned gap;
        if (burst_left <= 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 10);
        end
        i_in_valid     <= 1'b1;
        i_msg_id       <= id;
        i_arrival_time <= stamp;
        do @(posedge i_clk); while (!o_in_ready);
        burst_left--;
    endtask

    // Write one register; the caller lowers the write enable
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        sb.set_register(idx, data);
    endtask

    task automatic load_settings(logic [ID_W-1:0] first, logic [ID_W-1:0] last,
                                 logic [TS_W-1:0] lo, logic [TS_W-1:0] hi);
        write_reg(CFG_ID_FIRST, 32'(first));
        write_reg(CFG_ID_LAST, 32'(last));
        write_reg(CFG_INTERVAL_MIN, lo);
        write_reg(CFG_INTERVAL_MAX, hi);
        i_cfg_we <= 1'b0;
    endtask

    // Drop valid and wait until every expected report has come back
    task automatic settle();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Mostly in-window ids with plausible spacing, plus edge and noise items
    task automatic run_random_phase(int unsigned count);
        logic [ID_W-1:0] id;
        logic [TS_W-1:0] stamp;
        logic [3:0]      slot;
        int unsigned     span;
        int unsigned     pick;
        span = 0;
        if (sb.win_last >= sb.win_first)
            span = ((sb.win_last - sb.win_first) > 15) ? 15 : (sb.win_last - sb.win_first);
        for (int unsigned n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 80)
                id = sb.win_first + ID_W'($urandom_range(0, span));
            else if (pick < 87)
                id = sb.win_first + ID_W'(span + 1);
            else if (pick < 94)
                id = sb.win_first - ID_W'($urandom_range(1, 3));
            else
                id = ID_W'($urandom);
            slot = 4'(id - sb.win_first);
            pick = $urandom_range(0, 99);
            if (pick < 70)
                stamp = stamp_track[slot] + TS_W'($urandom_range(0, 400));
            else if (pick < 80)
                stamp = stamp_track[slot] + TS_W'($urandom_range(0, 3));
            else if (pick < 90)
                stamp = $urandom;
            else if (pick < 95)
                stamp = '0;
            else
                stamp = stamp_track[slot] - TS_W'($urandom_range(1, 50));
            stamp_track[slot] = stamp;
            push_message(id, stamp);
        end
        settle();
    endtask

    initial begin
        logic [ID_W-1:0] first;
        sb = new();
        for (int k = 0; k < 16; k++)
            stamp_track[k] = '0;

        // Hold reset, then release
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset window and limits
        push_message(ID_W'(0), 32'd0);            // zero stamp stored as never seen
        push_message(ID_W'(0), 32'd100);          // still no previous arrival
        push_message(ID_W'(0), 32'd250);
        push_message(ID_W'(0), 32'd10);           // wrapping interval
        push_message(ID_W'(0), 32'd10);           // zero interval
        push_message(ID_W'(15), 32'hFFFF_FFFF);
        push_message(ID_W'(15), 32'h0000_0005);   // wraps past the top
        push_message(ID_W'(16), 32'd77);          // just past the window
        push_message(ID_W'(29'h1FFF_FFFF), 32'hFFFF_FFFF);
        push_message(ID_W'(7), 32'h8000_0000);
        push_message(ID_W'(7), 32'h7FFF_FFFF);    // largest interval
        settle();

        // Directed: window at the top of the id range, narrow limits
        load_settings(ID_W'(29'h1FFF_FFF0), ID_W'(29'h1FFF_FFFF), 32'd100, 32'd200);
        push_message(ID_W'(29'h1FFF_FFFF), 32'd1);
        push_message(ID_W'(29'h1FFF_FFFF), 32'd50);    // below the floor
        push_message(ID_W'(29'h1FFF_FFFF), 32'd400);   // above the ceiling
        push_message(ID_W'(29'h1FFF_FFFF), 32'd550);
        push_message(ID_W'(29'h1FFF_FFF0), 32'd9);
        push_message(ID_W'(29'h1FFF_FFEF), 32'd9);     // one below the window
        settle();

        // Directed: window clipped to the table size, inverted limits
        load_settings(ID_W'(40), ID_W'(29'h1FFF_FFFF), 32'hFFFF_FFFF, 32'd0);
        push_message(ID_W'(55), 32'd1000);
        push_message(ID_W'(55), 32'd1001);
        push_message(ID_W'(56), 32'd1002);             // beyond the table
        push_message(ID_W'(39), 32'd1003);
        settle();

        // Directed: inverted window
        load_settings(ID_W'(9), ID_W'(8), 32'd0, 32'hFFFF_FFFF);
        push_message(ID_W'(8), 32'd5);
        push_message(ID_W'(9), 32'd6);
        settle();

        // Random phases over a range of settings
        load_settings(ID_W'(0), ID_W'(15), 32'd50, 32'd200);
        run_random_phase(260);
        load_settings(ID_W'(29'h1FFF_FFF0), ID_W'(29'h1FFF_FFFF), 32'd0, 32'd0);
        run_random_phase(240);
        load_settings(ID_W'(1000), ID_W'(1007), 32'hFFFF_FFFF, 32'd0);
        run_random_phase(240);
        first = ID_W'($urandom_range(0, 32'h1FFF_FF00));
        load_settings(first, first + ID_W'($urandom_range(0, 24)),
                      TS_W'($urandom_range(0, 100)), TS_W'($urandom_range(100, 400)));
        run_random_phase(240);
        load_settings(ID_W'(0), ID_W'(29'h1FFF_FFFF), 32'd0, 32'hFFFF_FFFF);
        run_random_phase(240);
        load_settings(ID_W'(9), ID_W'(8), 32'd20, 32'd300);
        run_random_phase(30);
        load_settings(ID_W'(0), ID_W'(0), 32'd1, 32'hFFFF_FFFE);
        run_random_phase(200);

        if (sb.mismatch_cnt == 0 && sb.pending() == 0)
            $display("PASS message_interval_monitor");
        else
            $display("FAIL message_interval_monitor");
        $finish;
    end

endmodule
